// ===== hdl/sii_pkg.sv =====
// ----------------------------------------------------------------------------
// sii_pkg: shared constants and types for the squared integral image block
// Field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package sii_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W       = 8;
    localparam int SQ_W        = 2 * PIX_W;
    localparam int SUM_W       = 36;
    localparam int CFG_SIZE_W  = 11;
    localparam int CFG_INDEX_W = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_SIZE_W-1:0]  cfg_data_t;
    typedef logic [PIX_W-1:0]       pixel_t;
    typedef logic [SUM_W-1:0]       sum_t;

    localparam cfg_index_t REG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 2'd1;
    localparam cfg_index_t REG_BINARY_MODE  = 2'd2;

    localparam cfg_data_t RST_IMAGE_WIDTH  = 11'd1024;
    localparam cfg_data_t RST_IMAGE_HEIGHT = 11'd1024;

endpackage

// ===== hdl/squared_integral_image.sv =====
// ----------------------------------------------------------------------------
// squared_integral_image: streaming integral image of squared pixels
// An accepted pixel passes the stage 1 registers and then the output register.
// Throughput: one pixel per cycle while the output is not stalled; the line store
// has one write and one registered read per cycle, and a write-to-read bypass covers one-pixel rows.
// Reset clears counters, row sum, pipeline valids and the size/mode registers
// (1024 x 1024, 8-bit mode); line store contents are undefined until written.
// ----------------------------------------------------------------------------
module squared_integral_image #(
    parameter int MAX_WIDTH  = sii_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sii_pkg::DEF_MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  sii_pkg::cfg_index_t cfg_index,
    input  sii_pkg::cfg_data_t  cfg_data,

    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  sii_pkg::pixel_t     pixel_value,

    output logic                result_valid,
    input  logic                result_ready,
    output sii_pkg::sum_t       square_sum,
    output logic                row_end,
    output logic                frame_end
);

    import sii_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WCMP = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
    localparam int HCMP = (RW + 1 > CFG_SIZE_W) ? RW + 1 : CFG_SIZE_W;
    localparam int RSW  = SQ_W + CW;

    // configuration
    cfg_data_t width_reg;
    cfg_data_t height_reg;
    logic      binary_reg;

    // position counters
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    // stage 1
    logic            s1_valid_reg;
    logic [SQ_W-1:0] s1_sq_reg;
    logic [CW-1:0]   s1_col_reg;
    logic            s1_top_row_reg;
    logic            s1_last_col_reg;
    logic            s1_last_row_reg;
    logic            s1_fwd_hit_reg;
    sum_t            s1_fwd_data_reg;
    sum_t            rd_data_reg;

    logic [RSW-1:0] row_sum_reg;
    logic [RSW-1:0] row_sum_next;

    // output register
    logic out_valid_reg;
    sum_t out_sum_reg;
    logic out_row_end_reg;
    logic out_frame_end_reg;

    sum_t line_mem [MAX_WIDTH];

    logic [WCMP-1:0] width_eff;
    logic [HCMP-1:0] height_eff;
    logic            last_col;
    logic            last_row;
    logic [PIX_W-1:0] pix_eff;
    logic [SQ_W-1:0] sq;
    logic            accept;
    logic            out_free;
    logic            s1_adv;
    sum_t            above;
    sum_t            total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            binary_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_BINARY_MODE:  binary_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        width_eff = WCMP'(width_reg);
        if (width_eff == '0)
            width_eff = WCMP'(1);
        else if (width_eff > WCMP'(MAX_WIDTH))
            width_eff = WCMP'(MAX_WIDTH);

        height_eff = HCMP'(height_reg);
        if (height_eff == '0)
            height_eff = HCMP'(1);
        else if (height_eff > HCMP'(MAX_HEIGHT))
            height_eff = HCMP'(MAX_HEIGHT);
    end

    assign last_col = (WCMP'(col_reg) + WCMP'(1)) >= width_eff;
    assign last_row = (HCMP'(row_reg) + HCMP'(1)) >= height_eff;
    assign pix_eff  = binary_reg ? {{(PIX_W-1){1'b0}}, pixel_value[0]} : pixel_value;
    assign sq       = SQ_W'(pix_eff) * SQ_W'(pix_eff);

    assign out_free    = !out_valid_reg || result_ready;
    assign s1_adv      = s1_valid_reg && out_free;
    assign pixel_ready = !s1_valid_reg || s1_adv;
    assign accept      = pixel_valid && pixel_ready;

    assign row_sum_next = row_sum_reg + RSW'(s1_sq_reg);
    assign above = s1_top_row_reg ? '0 : (s1_fwd_hit_reg ? s1_fwd_data_reg : rd_data_reg);
    assign total = SUM_W'(row_sum_next) + above;

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // control of stage 1 and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_sum_reg   <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            if (s1_adv)
                row_sum_reg <= s1_last_col_reg ? '0 : row_sum_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sq_reg       <= sq;
            s1_col_reg      <= col_reg;
            s1_top_row_reg  <= (row_reg == '0);
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            // store write to the same column this cycle is not seen by the read
            s1_fwd_hit_reg  <= s1_adv && (s1_col_reg == col_reg);
            s1_fwd_data_reg <= total;
        end
        if (s1_adv)
        begin
            out_sum_reg       <= total;
            out_row_end_reg   <= s1_last_col_reg;
            out_frame_end_reg <= s1_last_col_reg && s1_last_row_reg;
        end
    end

    // line store
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[col_reg];
        if (s1_adv)
            line_mem[s1_col_reg] <= total;
    end

    assign result_valid = out_valid_reg;
    assign square_sum   = out_sum_reg;
    assign row_end      = out_row_end_reg;
    assign frame_end    = out_frame_end_reg;

    a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_frame_end_reg || out_row_end_reg))
        else $error("frame end without row end");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel lost before stage 1");

    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a pixel in stage 1");

    a_row_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_col_reg |=> row_sum_reg == '0)
        else $error("row sum not cleared at row end");

endmodule

// ===== sim/squared_integral_image_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// squared_integral_image_tb: self-checking bench for the squared integral image
// Streams raster pixels through random request gaps and output stalls, keeps
// its own row sum and line store to work out each pixel's integral of squares,
// and compares every result field against that prediction in order.
// ----------------------------------------------------------------------------
module squared_integral_image_tb;
    import sii_pkg::*;

    localparam int LINE_LEN      = DEF_MAX_WIDTH;
    localparam int ROWS_MAX      = DEF_MAX_HEIGHT;
    localparam int DRAIN_CYCLES  = 4;
    localparam int HOLD_LIMIT    = 2000;
    localparam int RANDOM_PIXELS = 280;
    localparam int IDLE_PCT      = 13;

    typedef struct packed {
        sum_t sum;
        logic row_end;
        logic frame_end;
    } integral_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index   = REG_IMAGE_WIDTH;
    cfg_data_t  cfg_data    = '0;
    logic       pixel_valid = 1'b0;
    logic       pixel_ready;
    pixel_t     pixel_value = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    sum_t       square_sum;
    logic       row_end;
    logic       frame_end;

    // expected integrals, oldest first
    integral_t   pending_integrals[$];
    sum_t        line_sums [LINE_LEN];
    sum_t        row_sum      = '0;
    int unsigned col_pos      = 0;
    int unsigned row_pos      = 0;
    int unsigned width_reg    = RST_IMAGE_WIDTH;
    int unsigned height_reg   = RST_IMAGE_HEIGHT;
    logic        binary_reg   = 1'b0;
    bit          no_idle      = 1'b0;
    int          error_count  = 0;
    int          quiet_cycles = 0;

    squared_integral_image u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .square_sum   (square_sum),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function void integrate_pixel(pixel_t v);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        pixel_t      p;
        logic [15:0] sq;
        sum_t        above;
        sum_t        total;
        logic        last_col;
        logic        last_row;
        w = clamp_dim(width_reg, LINE_LEN);
        h = clamp_dim(height_reg, ROWS_MAX);
        p = binary_reg ? {7'b0, v[0]} : v;
        col = (col_pos >= LINE_LEN) ? LINE_LEN - 1 : col_pos;
        sq = {8'b0, p} * {8'b0, p};
        row_sum = row_sum + sum_t'(sq);
        above = (row_pos != 0) ? line_sums[col] : '0;
        total = row_sum + above;
        line_sums[col] = total;
        last_col = (col + 1 >= w);
        last_row = (row_pos + 1 >= h);
        pending_integrals.push_back('{sum: total, row_end: last_col,
                                      frame_end: last_col && last_row});
        if (last_col)
        begin
            col_pos = 0;
            row_sum = '0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col + 1;
        end
    endfunction

    function void apply_reg(cfg_index_t idx, cfg_data_t data);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg  = 32'(data);
            REG_IMAGE_HEIGHT: height_reg = 32'(data);
            REG_BINARY_MODE:  binary_reg = data[0];
            default: ;
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return '1;
        return pixel_t'($urandom_range(255));
    endfunction

    function automatic cfg_data_t random_size(int unsigned typical);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return '0;
        if (pick < 8)
            return RST_IMAGE_WIDTH;
        if (pick < 12)
            return cfg_data_t'($urandom_range(2047, LINE_LEN + 1));
        if (pick < 25)
            return cfg_data_t'($urandom_range(64, 1));
        return cfg_data_t'($urandom_range(typical, 1));
    endfunction

    task wait_drained();
        pixel_valid <= 1'b0;
        while (pending_integrals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_reg(cfg_index_t idx, cfg_data_t data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    task send_pixel(pixel_t v);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_value <= v;
        do @(posedge clk); while (!pixel_ready);
        integrate_pixel(v);
    endtask

    task test_reset_defaults();
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h80);
        send_pixel(8'h01);
    endtask

    // fills every line store entry: completes a 1024-pixel row, then goes into row 1
    task test_full_width();
        write_reg(REG_IMAGE_WIDTH, 11'h7FF);
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        while (col_pos != 0)
            send_pixel(pixel_t'($urandom_range(255)));
        repeat (6) send_pixel(8'hFF);
    endtask

    task test_shrink_mid_frame();
        write_reg(REG_IMAGE_WIDTH, 11'd4);
        send_pixel(8'hFF);
        repeat (8) send_pixel(8'hFF);
        repeat (6) send_pixel(8'hFE);
        write_reg(REG_IMAGE_HEIGHT, 11'd1);
        send_pixel(8'h7F);
        send_pixel(8'h01);
    endtask

    task test_zero_size();
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_IMAGE_HEIGHT, 11'd0);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        write_reg(REG_IMAGE_HEIGHT, 11'h7FF);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h01);
    endtask

    task test_binary_mode();
        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        write_reg(REG_BINARY_MODE, 11'h7FF);
        send_pixel(8'hFF);
        send_pixel(8'hFE);
        send_pixel(8'h01);
        send_pixel(8'h80);
        send_pixel(8'h7F);
        send_pixel(8'hFF);
        write_reg(REG_BINARY_MODE, 11'h002);
        send_pixel(8'hFF);
        send_pixel(8'hFE);
        send_pixel(8'h01);
    endtask

    // one-pixel rows, back to back: exercises the store bypass
    task test_single_column();
        write_reg(REG_IMAGE_WIDTH, 11'd1);
        write_reg(REG_IMAGE_HEIGHT, 11'd3);
        no_idle = 1'b1;
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        no_idle = 1'b0;
    endtask

    task test_random_frames();
        int sent;
        int burst;
        int pick;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                write_reg(REG_IMAGE_WIDTH, random_size(12));
            else if (pick < 22)
                write_reg(REG_IMAGE_HEIGHT, random_size(6));
            else if (pick < 28)
                write_reg(REG_BINARY_MODE, cfg_data_t'($urandom_range(2047)));
            else if (pick < 32)
                wait_drained();
            burst = $urandom_range(40, 1);
            no_idle = (sent >= 100 && sent < 220);
            repeat (burst)
            begin
                send_pixel(random_pixel());
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        integral_t want;
        if (result_valid && result_ready)
        begin
            if (pending_integrals.size() == 0)
            begin
                $error("square_sum: expected none, actual %0d", square_sum);
                error_count++;
            end
            else
            begin
                want = pending_integrals.pop_front();
                if (square_sum !== want.sum)
                begin
                    $error("square_sum: expected %0d, actual %0d", want.sum, square_sum);
                    error_count++;
                end
                if (row_end !== want.row_end)
                begin
                    $error("row_end: expected %0d, actual %0d", want.row_end, row_end);
                    error_count++;
                end
                if (frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0d, actual %0d", want.frame_end, frame_end);
                    error_count++;
                end
            end
        end
        result_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        if ((pixel_valid && pixel_ready) || (cfg_valid && cfg_ready)
            || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HOLD_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_full_width();
        test_shrink_mid_frame();
        test_zero_size();
        test_binary_mode();
        test_single_column();
        test_random_frames();
        wait_drained();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sii_pkg.sv
hdl/squared_integral_image.sv
sim/squared_integral_image_tb.sv
